/* design/ert_pkg.sv */
// Shared types, field layout and constants of the extended RTC timekeeper.
package ert_pkg;

  // Input word layout: tdata carries the set arguments, tuser the function code.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 3;
  localparam int IN_SEC_LSB = 0;
  localparam int IN_SEC_MSB = 39;
  localparam int IN_NS_LSB  = 40;
  localparam int IN_NS_MSB  = 70;

  // Output word layout: tdata carries the time fields, tuser the status code.
  localparam int OUT_DATA_W   = 264;
  localparam int OUT_USER_W   = 2;
  localparam int OUT_TICK_LSB = 0;
  localparam int OUT_TICK_MSB = 54;
  localparam int OUT_SEC_LSB  = 55;
  localparam int OUT_SEC_MSB  = 104;
  localparam int OUT_NS_LSB   = 105;
  localparam int OUT_NS_MSB   = 134;
  localparam int OUT_MS_LSB   = 135;
  localparam int OUT_MS_MSB   = 198;
  localparam int OUT_US_LSB   = 199;
  localparam int OUT_US_MSB   = 262;
  localparam int OUT_RTS_BIT  = 263;

  typedef logic [2:0] func_t;
  localparam func_t FUNC_TICK      = 3'd0;
  localparam func_t FUNC_READ_SYS  = 3'd1;
  localparam func_t FUNC_READ_REAL = 3'd2;
  localparam func_t FUNC_SET_REAL  = 3'd3;
  localparam func_t FUNC_UNSET     = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_NOT_SET = 2'd1;
  localparam status_t STATUS_BAD_ARG = 2'd2;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [20:0] NS_MUL     = 21'd1953125;
  localparam logic [9:0]  MS_MUL     = 10'd1000;
  localparam logic [13:0] US_MUL     = 14'd15625;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic ld_lf;
    logic ld_prod;
    logic ld_sum;
    logic finish;
  } ert_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } ert_stat_t;

endpackage

/* design/extended_rtc_timekeeper.sv */
// Top level of the extended RTC timekeeper: stream ports, controller and datapath.
// Each accepted input word passes through the controller steps (prescale multiply,
// constant multiplies, sums, final select) before its result word is registered.
// A new word is taken while idle or as the last result is loaded, and an output stall holds it.
// Reset (rst, synchronous, active high) clears the RTC and half-interval counts,
// the real-time base, the prescaler and the output valid flag.
module extended_rtc_timekeeper #(
  parameter int COUNTER_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  // Prescaler register write port.
  input  logic                            rtc_prescaler_we,
  input  logic [11:0]                     rtc_prescaler_wdata,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: set_seconds[39:0], set_nanoseconds[70:40], zero pad [71].
  input  logic [ert_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: func[2:0].
  input  logic [ert_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: tick_total[54:0], seconds[104:55], nanoseconds[134:105],
  // milliseconds[198:135], microseconds[262:199], real_time_set[263].
  output logic [ert_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: status[1:0].
  output logic [ert_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  ert_pkg::ert_cmd_t  cmd;
  ert_pkg::ert_stat_t stat;

  // The controller walks one word at a time through the datapath. It takes the
  // next word in the same cycle in which the finished result is loaded into the
  // output register, so a waiting result never blocks the following request
  // for longer than the output side stalls.
  ert_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the counters and the real-time base. The extended tick
  // count is the half-interval count over the low RTC bits; system time is that
  // count times the prescale factor in 32768 Hz cycles, and the wide multiplies are
  // split into 32-bit halves, with their results registered.
  ert_dp #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (s_axis_tuser),
    .set_seconds     (s_axis_tdata[ert_pkg::IN_SEC_MSB:ert_pkg::IN_SEC_LSB]),
    .set_nanoseconds (s_axis_tdata[ert_pkg::IN_NS_MSB:ert_pkg::IN_NS_LSB]),
    .cfg_we          (rtc_prescaler_we),
    .cfg_wdata       (rtc_prescaler_wdata),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_data        (m_axis_tdata),
    .out_status      (m_axis_tuser)
  );

endmodule

/* design/ert_ctrl.sv */
// Sequencing state machine of the extended RTC timekeeper.
module ert_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output ert_pkg::ert_cmd_t cmd,
  input  ert_pkg::ert_stat_t stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PROD = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    in_ready   = (state == ST_IDLE) || ((state == ST_DONE) && stat.out_free);
    cmd        = '0;
    cmd.accept = in_valid && in_ready;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.ld_lf  = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.ld_prod = 1'b1;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        cmd.ld_sum = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = cmd.accept ? ST_MUL : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/ert_dp.sv */
// Counters, time base and arithmetic datapath of the extended RTC timekeeper.
module ert_dp #(
  parameter int COUNTER_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ert_pkg::ert_cmd_t                 cmd,
  output ert_pkg::ert_stat_t                stat,
  input  ert_pkg::func_t                    func,
  input  logic [39:0]                       set_seconds,
  input  logic [30:0]                       set_nanoseconds,
  input  logic                              cfg_we,
  input  logic [11:0]                       cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ert_pkg::OUT_DATA_W-1:0]    out_data,
  output ert_pkg::status_t                  out_status
);

  localparam int TOT_W = COUNTER_BITS + 31;

  // Control state, cleared by reset.
  logic [COUNTER_BITS-1:0] rtc_count;
  logic [31:0]             half_count;
  logic [63:0]             base_s;
  logic [30:0]             base_ns;
  logic [11:0]             prescaler;

  // Latched request.
  ert_pkg::func_t func_r;
  logic [39:0]    rs_r;
  logic [30:0]    rn_r;

  // Pipeline of the time computation.
  logic [63:0] lf;
  logic [35:0] ns_prod;
  logic [41:0] ms_lo;
  logic [31:0] ms_hi;
  logic [45:0] us_lo;
  logic [31:0] us_hi;
  logic [48:0] ms_r;
  logic [54:0] us_r;
  logic [29:0] sys_ns;
  logic [63:0] rsum_s;
  logic [31:0] rsum_ns;
  logic [63:0] dset_s;
  logic [31:0] dset_ns;

  logic [COUNTER_BITS-1:0] rtc_inc;
  logic [TOT_W-1:0]        tot;
  logic [63:0]             tot_ext;
  logic [12:0]             p1;
  logic [44:0]             lf_lo_prod, lf_hi_prod;
  logic [63:0]             lf_next;
  logic [35:0]             ns_prod_next;
  logic [41:0]             ms_lo_next, ms_hi_prod;
  logic [45:0]             us_lo_next, us_hi_prod;
  logic [63:0]             ms_full, us_full, sys_s;
  logic [29:0]             sys_ns_next;
  logic [63:0]             rsum_s_next, dset_s_next;
  logic [31:0]             rsum_ns_next, dset_ns_next;

  logic                    carry, set_ok, borrow, rts_out;
  logic [63:0]             real_s, new_bs, secs, ms_out, us_out;
  logic [31:0]             real_ns, new_bns_w;
  logic [29:0]             nsec;
  logic [63:0]             base_s_next;
  logic [30:0]             base_ns_next;
  ert_pkg::status_t        status;

  // Top bit of the RTC count always equals the low bit of the half count,
  // so the extended count is the plain concatenation.
  assign rtc_inc = rtc_count + COUNTER_BITS'(1);
  assign tot     = {half_count, rtc_count[COUNTER_BITS-2:0]};
  assign tot_ext = 64'(tot);

  always_comb begin
    p1         = {1'b0, prescaler} + 13'd1;
    lf_lo_prod = 45'(tot[31:0]) * 45'(p1);
    lf_hi_prod = 45'(tot[TOT_W-1:32]) * 45'(p1);
    lf_next    = 64'(lf_lo_prod) + {lf_hi_prod[31:0], 32'd0};

    ns_prod_next = 36'(lf[14:0]) * 36'(ert_pkg::NS_MUL);
    ms_lo_next   = 42'(lf[31:0]) * 42'(ert_pkg::MS_MUL);
    ms_hi_prod   = 42'(lf[63:32]) * 42'(ert_pkg::MS_MUL);
    us_lo_next   = 46'(lf[31:0]) * 46'(ert_pkg::US_MUL);
    us_hi_prod   = 46'(lf[63:32]) * 46'(ert_pkg::US_MUL);

    sys_s        = {15'd0, lf[63:15]};
    ms_full      = 64'(ms_lo) + {ms_hi, 32'd0};
    us_full      = 64'(us_lo) + {us_hi, 32'd0};
    sys_ns_next  = ns_prod[35:6];
    rsum_s_next  = sys_s + base_s;
    rsum_ns_next = 32'(sys_ns_next) + 32'(base_ns);
    dset_s_next  = 64'(rs_r) - sys_s;
    dset_ns_next = 32'(rn_r) - 32'(sys_ns_next);
  end

  always_comb begin
    carry     = rsum_ns >= ert_pkg::NS_PER_SEC;
    real_s    = carry ? rsum_s + 64'd1 : rsum_s;
    real_ns   = carry ? rsum_ns - ert_pkg::NS_PER_SEC : rsum_ns;
    set_ok    = !rs_r[39] && !rn_r[30] && (32'(rn_r) < ert_pkg::NS_PER_SEC);
    borrow    = dset_ns[31];
    new_bs    = borrow ? dset_s - 64'd1 : dset_s;
    new_bns_w = borrow ? dset_ns + ert_pkg::NS_PER_SEC : dset_ns;

    status       = ert_pkg::STATUS_OK;
    secs         = '0;
    nsec         = '0;
    ms_out       = '0;
    us_out       = '0;
    base_s_next  = base_s;
    base_ns_next = base_ns;
    case (func_r)
      ert_pkg::FUNC_READ_SYS: begin
        secs   = sys_s;
        nsec   = sys_ns;
        ms_out = {15'd0, ms_r};
        us_out = {9'd0, us_r};
      end
      ert_pkg::FUNC_READ_REAL: begin
        if ((base_s == '0) && (base_ns == '0)) begin
          status = ert_pkg::STATUS_NOT_SET;
        end else begin
          secs = real_s;
          nsec = real_ns[29:0];
        end
      end
      ert_pkg::FUNC_SET_REAL: begin
        if (!set_ok) begin
          status = ert_pkg::STATUS_BAD_ARG;
        end else begin
          base_s_next  = new_bs;
          base_ns_next = new_bns_w[30:0];
        end
      end
      ert_pkg::FUNC_UNSET: begin
        base_s_next  = '0;
        base_ns_next = '0;
      end
      default: begin
      end
    endcase
    rts_out = (base_s_next != '0) || (base_ns_next != '0);
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler  <= '0;
      rtc_count  <= '0;
      half_count <= '0;
      base_s     <= '0;
      base_ns    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) prescaler <= cfg_wdata;
      if (cmd.accept && (func == ert_pkg::FUNC_TICK)) begin
        rtc_count <= rtc_inc;
        if (rtc_inc[COUNTER_BITS-2:0] == '0) half_count <= half_count + 32'd1;
      end
      if (cmd.finish) begin
        base_s  <= base_s_next;
        base_ns <= base_ns_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= func;
      rs_r   <= set_seconds;
      rn_r   <= set_nanoseconds;
    end
    if (cmd.ld_lf) lf <= lf_next;
    if (cmd.ld_prod) begin
      ns_prod <= ns_prod_next;
      ms_lo   <= ms_lo_next;
      ms_hi   <= ms_hi_prod[31:0];
      us_lo   <= us_lo_next;
      us_hi   <= us_hi_prod[31:0];
    end
    if (cmd.ld_sum) begin
      ms_r    <= ms_full[63:15];
      us_r    <= us_full[63:9];
      sys_ns  <= sys_ns_next;
      rsum_s  <= rsum_s_next;
      rsum_ns <= rsum_ns_next;
      dset_s  <= dset_s_next;
      dset_ns <= dset_ns_next;
    end
    if (cmd.finish) begin
      out_data   <= {rts_out, us_out, ms_out, nsec, secs[49:0], tot_ext[54:0]};
      out_status <= status;
    end
  end

endmodule

/* design/ert_checker.sv */
// Port-level checker of the extended RTC timekeeper, with its bind statement.
module ert_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            rtc_prescaler_we,
  input logic [11:0]                     rtc_prescaler_wdata,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [ert_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [ert_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ert_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [ert_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  // After reset the block is empty and ready for a word.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not idle after reset");

  // After a word is accepted, no other can be taken while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=>
      !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("input accepted while a word is in progress");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

  // A "not set" answer reports no base and zero seconds.
  a_not_set: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ert_pkg::STATUS_NOT_SET)) |->
      (!m_axis_tdata[ert_pkg::OUT_RTS_BIT] &&
       (m_axis_tdata[ert_pkg::OUT_SEC_MSB:ert_pkg::OUT_SEC_LSB] == '0)))
    else $error("not-set status with real time fields");

  // Nanoseconds stay within one second.
  a_ns_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (32'(m_axis_tdata[ert_pkg::OUT_NS_MSB:ert_pkg::OUT_NS_LSB]) < ert_pkg::NS_PER_SEC))
    else $error("nanoseconds out of range");

endmodule

bind extended_rtc_timekeeper ert_checker u_ert_checker (.*);
